// ===== hdl/csq_pkg.sv =====
package csq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int MAXC_W      = 8;
  localparam int WAITERS_W   = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_ORDER = 1'b1;

  localparam logic ACT_WAIT = 1'b0;
  localparam logic ACT_POST = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    logic   prio_mode;
    entry_t new_entry;
  } cmd_t;

endpackage

// ===== hdl/counting_semaphore_wait_queue_unit.sv =====
// Counting semaphore with a 16-entry wait queue held in a row of cells. Each
// accepted item is captured in the idle state; in the exec state the cell row
// inserts or releases an entry (shifting by one cell) and the count updates;
// the result then sits in the output register while the next item is taken.
// The unit takes no new item until the exec step of the last one is done, and
// an untaken result holds the exec step. The queue needs no clearing after
// reset: only occupied cells are read. Write max_count and priority_order
// only while no item is in flight.
module counting_semaphore_wait_queue_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [csq_pkg::ID_W-1:0]          in_task_id,
  input  logic [csq_pkg::PRIO_W-1:0]        in_task_priority,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_blocked,
  output logic                              out_overflow,
  output logic                              out_woken_valid,
  output logic [csq_pkg::ID_W-1:0]          out_woken_id,
  output logic signed [csq_pkg::COUNT_W-1:0] out_count_now,
  output logic [csq_pkg::WAITERS_W-1:0]     out_waiters,
  input  logic                              cfg_we,
  input  logic [csq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;
  localparam int   FILL_W  = csq_pkg::FILL_W;
  localparam int   CW      = csq_pkg::COUNT_W;

  logic                         state_r, state_nxt;
  logic [csq_pkg::MAXC_W-1:0]   max_count_r;
  logic                         prio_order_r;
  logic signed [CW-1:0]         sem_r, sem_nxt;
  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic                         act_r;
  csq_pkg::entry_t              item_r;

  logic                         out_valid_r;
  logic                         out_blocked_r, out_overflow_r, out_woken_valid_r;
  logic [csq_pkg::ID_W-1:0]     out_woken_id_r;
  logic signed [CW-1:0]         out_count_r;
  logic [FILL_W-1:0]            out_fill_r;

  logic                         exec;
  logic                         full;
  logic                         would_block;
  logic signed [CW:0]           sem_inc;
  logic signed [CW:0]           max_ext;
  logic signed [CW-1:0]         post_sem;
  logic                         blocked, overflow, woken;
  csq_pkg::cmd_t                cmd;
  csq_pkg::entry_t              head;

  assign in_ready = (state_r == ST_IDLE);
  assign exec     = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign full     = (fill_r == FILL_W'(csq_pkg::QUEUE_DEPTH));

  assign would_block = (sem_r <= 0);
  assign sem_inc     = {sem_r[CW-1], sem_r} + (CW+1)'(1);
  assign max_ext     = $signed({2'b00, max_count_r});
  assign post_sem    = (sem_inc > max_ext) ? CW'(max_ext) : CW'(sem_inc);

  assign blocked  = (act_r == csq_pkg::ACT_WAIT) && would_block && !full;
  assign overflow = (act_r == csq_pkg::ACT_WAIT) && would_block && full;
  assign woken    = (act_r == csq_pkg::ACT_POST) && (post_sem <= 0) &&
                    (fill_r != '0);

  assign cmd.ins       = exec && blocked;
  assign cmd.pop       = exec && woken;
  assign cmd.prio_mode = prio_order_r;
  assign cmd.new_entry = item_r;

  always_comb begin
    sem_nxt  = sem_r;
    fill_nxt = fill_r;
    if (act_r == csq_pkg::ACT_WAIT) begin
      if (!would_block) begin
        sem_nxt = sem_r - CW'(1);
      end else if (!full) begin
        fill_nxt = fill_r + FILL_W'(1);
        if (sem_r != {1'b1, {(CW-1){1'b0}}}) begin
          sem_nxt = sem_r - CW'(1);
        end
      end
    end else begin
      sem_nxt = post_sem;
      if (woken) begin
        fill_nxt = fill_r - FILL_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_count_r  <= csq_pkg::MAXC_W'(1);
      prio_order_r <= 1'b0;
      sem_r        <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          csq_pkg::REG_MAX_COUNT:  max_count_r  <= cfg_data;
          csq_pkg::REG_PRIO_ORDER: prio_order_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (exec) begin
        sem_r       <= sem_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r       <= in_action;
      item_r.id   <= in_task_id;
      item_r.prio <= in_task_priority;
    end
    if (exec) begin
      out_blocked_r     <= blocked;
      out_overflow_r    <= overflow;
      out_woken_valid_r <= woken;
      out_woken_id_r    <= woken ? head.id : '0;
      out_count_r       <= sem_nxt;
      out_fill_r        <= fill_nxt;
    end
  end

  csq_queue u_queue (
    .clk  (clk),
    .cmd  (cmd),
    .fill (fill_r),
    .head (head)
  );

  assign out_valid       = out_valid_r;
  assign out_blocked     = out_blocked_r;
  assign out_overflow    = out_overflow_r;
  assign out_woken_valid = out_woken_valid_r;
  assign out_woken_id    = out_woken_id_r;
  assign out_count_now   = out_count_r;
  assign out_waiters     = csq_pkg::WAITERS_W'(out_fill_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(csq_pkg::QUEUE_DEPTH))
    else $error("wait queue fill beyond depth");

  a_no_ins_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.pop))
    else $error("insert and release in one cycle");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("insert did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> fill_r == $past(fill_r) - FILL_W'(1))
    else $error("release did not shrink the queue");

  a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({out_blocked_r, out_overflow_r, out_woken_valid_r}) <= 1)
    else $error("conflicting result flags");

endmodule

// ===== hdl/csq_cell.sv =====
module csq_cell (
  input  logic            clk,
  input  csq_pkg::cmd_t   cmd,
  input  logic            occ,
  input  logic            tail,
  input  logic            found_in,
  output logic            found_out,
  input  csq_pkg::entry_t left_entry,
  input  csq_pkg::entry_t right_entry,
  output csq_pkg::entry_t entry
);

  csq_pkg::entry_t entry_r;
  csq_pkg::entry_t entry_nxt;
  logic            match;

  assign match     = occ && cmd.prio_mode && (cmd.new_entry.prio > entry_r.prio);
  assign found_out = found_in | match;
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (found_in) begin
        entry_nxt = left_entry;
      end else if (match || tail) begin
        entry_nxt = cmd.new_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hdl/csq_queue.sv =====
module csq_queue (
  input  logic                       clk,
  input  csq_pkg::cmd_t              cmd,
  input  logic [csq_pkg::FILL_W-1:0] fill,
  output csq_pkg::entry_t            head
);

  localparam int DEPTH = csq_pkg::QUEUE_DEPTH;

  csq_pkg::entry_t      cells [DEPTH];
  logic [DEPTH:0]       found;
  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     tail;

  assign found[0] = 1'b0;
  assign head     = cells[0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    csq_pkg::entry_t left_entry;
    csq_pkg::entry_t right_entry;

    assign occ[g]  = csq_pkg::FILL_W'(g) < fill;
    assign tail[g] = csq_pkg::FILL_W'(g) == fill;

    if (g == 0) begin : g_first
      assign left_entry = cmd.new_entry;
    end else begin : g_mid
      assign left_entry = cells[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_entry = cells[g];
    end else begin : g_inner
      assign right_entry = cells[g+1];
    end

    csq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ[g]),
      .tail        (tail[g]),
      .found_in    (found[g]),
      .found_out   (found[g+1]),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cells[g])
    );
  end

endmodule
